### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Entry geometry, command and status codes, and the controller-to-datapath
// command struct.
// ----------------------------------------------------------------------------
package deq_pkg;

	// queue geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// fixed field widths of the request and result
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CLEAR      = 3'd4,
		CMD_QUERY      = 3'd5
	} cmd_t;

	// status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_RESP = 2'd2
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic exec;   // apply the accepted request to pointers and store
		logic rd_en;  // capture front and back values
	} ctl_t;

endpackage

### hdl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if: request and result channels
// Valid/ready channels carrying the queue command and the queue result.
// ----------------------------------------------------------------------------
interface deq_in_if import deq_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [VALUE_W-1:0] data_in;

	modport source (output valid, output command, output data_in, input ready);
	modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface deq_out_if import deq_pkg::*;;
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  front_value;
	logic [VALUE_W-1:0]  back_value;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output front_value, output back_value, output count,
		output is_empty, output status, input ready);
	modport sink   (input valid, input front_value, input back_value, input count,
		input is_empty, input status, output ready);
endinterface

### hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: request sequencer of the double-ended queue
// Accepts one request, lets the datapath update and read back, then holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ctl       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctl.exec = in_valid;
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
			end
			S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### hdl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp: datapath of the double-ended queue
// Ring store with front and back pointers and an entry count, plus the
// registered result fields.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	input  logic [CMD_W-1:0]    command,
	input  logic [VALUE_W-1:0]  data_in,
	output logic [VALUE_W-1:0]  front_value,
	output logic [VALUE_W-1:0]  back_value,
	output logic [COUNT_W-1:0]  count,
	output logic                is_empty,
	output logic [STATUS_W-1:0] status
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [IDX_W-1:0] front_q, back_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] front_d, back_d;
	logic [CNT_W-1:0] cnt_d;
	logic [IDX_W-1:0] front_prev, front_next, back_prev, back_next;
	logic             full, empty;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	status_t          status_d;
	status_t          status_q;
	logic [VALUE_W-1:0] front_val_q, back_val_q;

	// ring neighbors of both pointers
	always_comb begin
		front_prev = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
		front_next = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
		back_prev  = (back_q == '0) ? IDX_W'(DEPTH - 1) : back_q - 1'b1;
		back_next  = (back_q == IDX_W'(DEPTH - 1)) ? '0 : back_q + 1'b1;
		full       = (cnt_q == CNT_W'(DEPTH));
		empty      = (cnt_q == '0);
	end

	// command decode: next pointers, count, write and status
	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		cnt_d    = cnt_q;
		wr_en    = 1'b0;
		wr_addr  = back_q;
		status_d = ST_OK;
		case (command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					front_d = front_prev;
					wr_en   = 1'b1;
					wr_addr = front_prev;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					back_d  = back_next;
					wr_en   = 1'b1;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d = front_next;
					cnt_d   = cnt_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					back_d = back_prev;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				front_d = '0;
				back_d  = '0;
				cnt_d   = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
		end else if (ctl.exec) begin
			front_q <= front_d;
			back_q  <= back_d;
			cnt_q   <= cnt_d;
		end
	end

	// status of the accepted request
	always_ff @(posedge clk) begin
		if (ctl.exec) status_q <= status_d;
	end

	// store write port
	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) mem[wr_addr] <= DATA_WIDTH'(data_in);
	end

	// store read ports, zero when empty
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			front_val_q <= empty ? '0 : VALUE_W'(mem[front_q]);
			back_val_q  <= empty ? '0 : VALUE_W'(mem[back_prev]);
		end
	end

	// result fields
	assign front_value = front_val_q;
	assign back_value  = back_val_q;
	assign count       = COUNT_W'(cnt_q);
	assign is_empty    = empty;
	assign status      = status_q;

endmodule

### hdl/double_ended_queue_top.sv
// Sequence: a request is accepted in S_IDLE, where pointers, count and store are
// updated; S_READ then captures the front and back values, and S_RESP offers the result.
// The sequencer holds one request from update through readback and takes no new
// request until the result is taken.
// Reset: arst_n clears the pointers, the count and the sequencer at once;
// store contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue
// Push and pop at either end of a ring store, with clear and query; each
// request returns the front and back values, count, empty flag and status.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	deq_in_if.sink    requests,
	deq_out_if.source results
);

	ctl_t ctl;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (requests.valid),
		.in_ready  (requests.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.ctl       (ctl)
	);

	deq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.command     (requests.command),
		.data_in     (requests.data_in),
		.front_value (results.front_value),
		.back_value  (results.back_value),
		.count       (results.count),
		.is_empty    (results.is_empty),
		.status      (results.status)
	);

endmodule

### hdl/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [VALUE_W-1:0]  front_value,
	input logic [VALUE_W-1:0]  back_value,
	input logic [COUNT_W-1:0]  count,
	input logic                is_empty,
	input logic [STATUS_W-1:0] status
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is open");

	// empty flag agrees with count, and count stays within the depth
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)) && (count <= COUNT_W'(DEPTH)))
		else $error("empty flag or count inconsistent");

	// empty queue shows zero values
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (front_value == '0) && (back_value == '0))
		else $error("nonzero value from empty queue");

	// full refusal only when full, pop error only when empty
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != ST_FULL || count == COUNT_W'(DEPTH))
			&& (status != ST_EMPTY || is_empty))
		else $error("status inconsistent with count");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (requests.valid),
	.in_ready    (requests.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.front_value (results.front_value),
	.back_value  (results.back_value),
	.count       (results.count),
	.is_empty    (results.is_empty),
	.status      (results.status)
);
